/* hw/rtl/dssg_pkg.sv */
// ----------------------------------------------------------------------------
// dssg_pkg
// Types, constants and the square root helper shared by the span generator.
// ----------------------------------------------------------------------------
package dssg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int OUT_BITS    = 13;
  localparam int RADIUS_BITS = 5;
  localparam int WIDTH_BITS  = 10;
  localparam int HEIGHT_BITS = 7;
  localparam int ROW_BITS    = 6;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;

  localparam int MAX_ROWS    = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  localparam logic MODE_CIRCLE = 1'b0;
  localparam logic MODE_RECT   = 1'b1;

  // One classified command, as handed from front to back.
  typedef struct packed {
    logic                        circ;
    logic signed [OUT_BITS-1:0]  x0;
    logic signed [OUT_BITS-1:0]  y0;
    logic [RADIUS_BITS-1:0]      r;
    logic [SQ_BITS-1:0]          r_sq;
    logic signed [OUT_BITS-1:0]  rect_last;
    logic [ROW_BITS-1:0]         rows_m1;
  } job_t;

  // Floor square root, digit by digit, two input bits per step.
  function automatic logic [RADIUS_BITS-1:0] isqrt(input logic [SQ_BITS-1:0] n);
    logic [RADIUS_BITS+1:0] rem;
    logic [RADIUS_BITS+1:0] trial;
    logic [RADIUS_BITS-1:0] root;
    rem  = '0;
    root = '0;
    for (int i = RADIUS_BITS - 1; i >= 0; i--) begin
      rem   = {rem[RADIUS_BITS-1:0], n[2*i+1 -: 2]};
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[RADIUS_BITS-2:0], 1'b1};
      end else begin
        root = {root[RADIUS_BITS-2:0], 1'b0};
      end
    end
    return root;
  endfunction

endpackage

/* hw/rtl/dssg_if.sv */
// ----------------------------------------------------------------------------
// dssg_in_if / dssg_out_if
// Valid/ready channels for shape commands and span results.
// ----------------------------------------------------------------------------
interface dssg_in_if import dssg_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [COORD_BITS-1:0]  pos_x;
  logic signed [COORD_BITS-1:0]  pos_y;
  logic [RADIUS_BITS-1:0]        radius;
  logic [WIDTH_BITS-1:0]         width;
  logic [HEIGHT_BITS-1:0]        height;

  modport source (output valid, mode, pos_x, pos_y, radius, width, height, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, radius, width, height, output ready);
endinterface

interface dssg_out_if import dssg_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_BITS-1:0]  row_y;
  logic signed [OUT_BITS-1:0]  first_x;
  logic signed [OUT_BITS-1:0]  last_x;
  logic                        has_pixels;
  logic                        last_row;

  modport source (output valid, row_y, first_x, last_x, has_pixels, last_row, input ready);
  modport sink   (input valid, row_y, first_x, last_x, has_pixels, last_row, output ready);
endinterface

/* hw/rtl/dssg_front.sv */
// ----------------------------------------------------------------------------
// dssg_front
// Accepts shape commands and turns them into row jobs for the back end.
// ----------------------------------------------------------------------------
module dssg_front import dssg_pkg::*; (
  dssg_in_if.sink   in_chan,
  input  logic      q_ready,
  output logic      q_push,
  output job_t      q_job
);

  logic signed [OUT_BITS-1:0] px;
  logic signed [OUT_BITS-1:0] py;
  logic [HEIGHT_BITS-1:0]     h_sat;
  logic                       empty_rect;

  assign px = OUT_BITS'(in_chan.pos_x);
  assign py = OUT_BITS'(in_chan.pos_y);

  always_comb begin
    h_sat = (in_chan.height > HEIGHT_BITS'(MAX_ROWS)) ? HEIGHT_BITS'(MAX_ROWS)
                                                      : in_chan.height;
    empty_rect = (in_chan.mode == MODE_RECT) && (in_chan.height == '0);
  end

  assign in_chan.ready = q_ready;
  assign q_push        = in_chan.valid && q_ready && !empty_rect;

  always_comb begin
    q_job.circ      = (in_chan.mode == MODE_CIRCLE);
    q_job.x0        = px;
    q_job.r         = in_chan.radius;
    q_job.r_sq      = SQ_BITS'(in_chan.radius * in_chan.radius);
    q_job.rect_last = px + $signed({{(OUT_BITS-WIDTH_BITS){1'b0}}, in_chan.width})
                      - OUT_BITS'(1);
    if (in_chan.mode == MODE_CIRCLE) begin
      q_job.y0      = py - $signed({{(OUT_BITS-RADIUS_BITS){1'b0}}, in_chan.radius});
      q_job.rows_m1 = {in_chan.radius, 1'b0};
    end else begin
      q_job.y0      = py;
      q_job.rows_m1 = ROW_BITS'(h_sat - HEIGHT_BITS'(1));
    end
  end

endmodule

/* hw/rtl/dssg_queue.sv */
// ----------------------------------------------------------------------------
// dssg_queue
// Short job FIFO between the command front end and the span back end.
// ----------------------------------------------------------------------------
module dssg_queue import dssg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   count_r, count_nxt;

  assign push_ready = (count_r != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(pop);
    count_nxt  = count_r + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready) else $error("push into full job queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("pop from empty job queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_BITS+1)'(QUEUE_DEPTH)) else $error("job queue count out of range");
`endif

endmodule

/* hw/rtl/dssg_back.sv */
// ----------------------------------------------------------------------------
// dssg_back
// Row sequencer, square root stage and output register for span results.
// ----------------------------------------------------------------------------
module dssg_back import dssg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  dssg_out_if.source  out_chan
);

  // job register and row counter
  logic                  job_valid_r, job_valid_nxt;
  job_t                  job_r;
  logic [ROW_BITS-1:0]   k_r, k_nxt;

  // stage 1: squared half width and row
  logic                        s1_valid_r;
  logic [SQ_BITS-1:0]          s1_n_r;
  logic signed [OUT_BITS-1:0]  s1_row_r;
  logic signed [OUT_BITS-1:0]  s1_x0_r;
  logic signed [OUT_BITS-1:0]  s1_rect_last_r;
  logic                        s1_circ_r;
  logic                        s1_last_r;

  // output register
  logic                        out_valid_r;
  logic signed [OUT_BITS-1:0]  out_row_r;
  logic signed [OUT_BITS-1:0]  out_first_r;
  logic signed [OUT_BITS-1:0]  out_last_r;
  logic                        out_has_r;
  logic                        out_final_r;

  logic                        advance;
  logic                        issue;
  logic                        last_k;
  logic signed [RADIUS_BITS+1:0] dy;
  logic [RADIUS_BITS-1:0]      dy_mag;
  logic [SQ_BITS-1:0]          n_row;
  logic [RADIUS_BITS-1:0]      dx;
  logic signed [OUT_BITS-1:0]  dx_s;
  logic signed [OUT_BITS-1:0]  base_x;
  logic signed [OUT_BITS-1:0]  first_x;
  logic signed [OUT_BITS-1:0]  last_x;

  assign advance = !out_valid_r || out_chan.ready;
  assign issue   = advance && job_valid_r;
  assign last_k  = (k_r == job_r.rows_m1);
  assign q_pop   = !job_valid_r && q_valid;

  always_comb begin
    job_valid_nxt = job_valid_r;
    k_nxt         = k_r;
    if (q_pop) begin
      job_valid_nxt = 1'b1;
      k_nxt         = '0;
    end else if (issue) begin
      if (last_k) begin
        job_valid_nxt = 1'b0;
      end else begin
        k_nxt = k_r + ROW_BITS'(1);
      end
    end
  end

  always_comb begin
    dy     = $signed({1'b0, k_r}) - $signed({2'b00, job_r.r});
    dy_mag = dy[RADIUS_BITS+1] ? RADIUS_BITS'(-dy) : dy[RADIUS_BITS-1:0];
    n_row  = job_r.r_sq - SQ_BITS'(dy_mag * dy_mag);
  end

  always_comb begin
    dx      = isqrt(s1_n_r);
    dx_s    = $signed({{(OUT_BITS-RADIUS_BITS){1'b0}}, dx});
    base_x  = s1_circ_r ? (s1_x0_r - dx_s) : s1_x0_r;
    last_x  = s1_circ_r ? (s1_x0_r + dx_s) : s1_rect_last_r;
    first_x = base_x + $signed({{(OUT_BITS-1){1'b0}}, base_x[0] ^ s1_row_r[0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      k_r         <= k_nxt;
      if (advance) begin
        s1_valid_r  <= issue;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (advance) begin
      s1_n_r         <= job_r.circ ? n_row : '0;
      s1_row_r       <= job_r.y0 + $signed({{(OUT_BITS-ROW_BITS){1'b0}}, k_r});
      s1_x0_r        <= job_r.x0;
      s1_rect_last_r <= job_r.rect_last;
      s1_circ_r      <= job_r.circ;
      s1_last_r      <= last_k;
      out_row_r      <= s1_row_r;
      out_first_r    <= first_x;
      out_last_r     <= last_x;
      out_has_r      <= (first_x <= last_x);
      out_final_r    <= s1_last_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.row_y      = out_row_r;
  assign out_chan.first_x    = out_first_r;
  assign out_chan.last_x     = out_last_r;
  assign out_chan.has_pixels = out_has_r;
  assign out_chan.last_row   = out_final_r;

`ifndef ASSERT_OFF
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_first_r[0] == out_row_r[0])) else $error("span parity broken");
  a_job_done: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && last_k) |=> !job_valid_r) else $error("job not retired after last row");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready && s1_valid_r) |=> (s1_valid_r && $stable(s1_row_r)))
    else $error("stage 1 moved during stall");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !job_valid_r) else $error("job loaded over active job");
`endif

endmodule

/* hw/rtl/dithered_shape_span_generator.sv */
// ----------------------------------------------------------------------------
// dithered_shape_span_generator
// Turns circle and rectangle commands into checkerboard-dithered row spans.
// ----------------------------------------------------------------------------
//  channel    dir  transaction
//  in_chan    in   one shape command (mode, pos_x, pos_y, radius, width, height)
//  out_chan   out  one span per row (row_y, first_x, last_x, has_pixels, last_row)
//
//  In the back end a command gives one span per row, one per cycle while
//  out_chan.ready is high, after a job load and a two stage square root /
//  span pipeline (2r+1 rows for a circle, min(height, 64) for a rectangle).
//  A two entry job queue lets the front take commands while spans drain.
//  A rectangle of height zero is accepted and gives no span. Reset clears
//  control state only; out_chan.ready low with a span held stalls the rows.
// ----------------------------------------------------------------------------
module dithered_shape_span_generator import dssg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dssg_in_if.sink    in_chan,
  dssg_out_if.source out_chan
);

  logic q_push;
  logic q_ready;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t pop_job;

  dssg_front u_front (
    .in_chan (in_chan),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  dssg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  dssg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

/* tb/sv/dssg_span_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dssg_span_checker
// Watches both channels of the span generator. For every accepted command it
// works out the dithered spans and queues them; every accepted span must match
// the oldest queued one. Hands the error count and the queue depth to the top.
// ----------------------------------------------------------------------------
module dssg_span_checker import dssg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dssg_in_if   in_mon,
  dssg_out_if  out_mon,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic signed [OUT_BITS-1:0] row_y;
    logic signed [OUT_BITS-1:0] first_x;
    logic signed [OUT_BITS-1:0] last_x;
    logic                       has_pixels;
    logic                       last_row;
  } span_t;

  span_t span_q[$];

  initial errors = 0;

  function automatic int floor_root(int n);
    int root;
    root = 0;
    while ((root + 1) * (root + 1) <= n)
      root++;
    return root;
  endfunction

  // First column steps right by one when x + y is odd.
  function automatic void add_span(int row, int x0, int last, bit fin);
    span_t s;
    int first;
    first        = x0 + ((x0 + row) & 1);
    s.row_y      = OUT_BITS'(row);
    s.first_x    = OUT_BITS'(first);
    s.last_x     = OUT_BITS'(last);
    s.has_pixels = (first <= last);
    s.last_row   = fin;
    span_q.push_back(s);
  endfunction

  function automatic void trace_shape_spans(logic m, logic signed [COORD_BITS-1:0] px_in,
                                            logic signed [COORD_BITS-1:0] py_in,
                                            logic [RADIUS_BITS-1:0] rad,
                                            logic [WIDTH_BITS-1:0] w,
                                            logic [HEIGHT_BITS-1:0] h);
    int px, py, r, wi, rows, dy, dx;
    px = int'(px_in);
    py = int'(py_in);
    if (m == MODE_CIRCLE) begin
      r    = int'(rad);
      rows = 2 * r + 1;
      if (rows > MAX_ROWS)
        rows = MAX_ROWS;
      for (int k = 0; k < rows; k++) begin
        dy = k - r;
        dx = floor_root(r * r - dy * dy);
        add_span(py + dy, px - dx, px + dx, k == rows - 1);
      end
    end else begin
      wi   = int'(w);
      rows = int'(h);
      if (rows > MAX_ROWS)
        rows = MAX_ROWS;
      for (int k = 0; k < rows; k++)
        add_span(py + k, px, px + wi - 1, k == rows - 1);
    end
  endfunction

  function automatic void report_miss(string what, span_t want, span_t got);
    errors++;
    if (errors <= 10) begin
      $write("%0t span mismatch (%s): exp row %0d first %0d last %0d pix %0b fin %0b",
             $realtime, what, want.row_y, want.first_x, want.last_x, want.has_pixels,
             want.last_row);
      $display(", got row %0d first %0d last %0d pix %0b fin %0b",
               got.row_y, got.first_x, got.last_x, got.has_pixels, got.last_row);
    end
  endfunction

  always @(posedge clk) begin
    span_t got, want;
    if (!rst_n) begin
      span_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.row_y, out_mon.first_x, out_mon.last_x,
                out_mon.has_pixels, out_mon.last_row};
        if (span_q.size() == 0) begin
          report_miss("unexpected", '0, got);
        end else begin
          want = span_q.pop_front();
          if (got.row_y !== want.row_y || got.first_x !== want.first_x ||
              got.last_x !== want.last_x || got.has_pixels !== want.has_pixels ||
              got.last_row !== want.last_row)
            report_miss("field", want, got);
        end
      end
      if (in_mon.valid && in_mon.ready)
        trace_shape_spans(in_mon.mode, in_mon.pos_x, in_mon.pos_y, in_mon.radius,
                          in_mon.width, in_mon.height);
    end
    pending <= span_q.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives shape commands into the span generator: a directed set of corner
// cases, then random circles and rectangles with random idling on both
// channels, one long output stall and a full drain midway. Gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import dssg_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 194;

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   hold_req;
  bit   hold_taken;
  int   errors;
  int   pending;
  int   cycles;

  dssg_in_if  in_chan();
  dssg_out_if out_chan();

  dithered_shape_span_generator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  dssg_span_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Span receiver: short random stalls, plus one long hold-off on request.
  initial begin : sink_side
    int n;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_chan.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // valid stays high across back-to-back commands; the task drops it only for a gap.
  task automatic send_shape(logic m, logic signed [COORD_BITS-1:0] px,
                            logic signed [COORD_BITS-1:0] py,
                            logic [RADIUS_BITS-1:0] r, logic [WIDTH_BITS-1:0] w,
                            logic [HEIGHT_BITS-1:0] h);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.mode   <= m;
    in_chan.pos_x  <= px;
    in_chan.pos_y  <= py;
    in_chan.radius <= r;
    in_chan.width  <= w;
    in_chan.height <= h;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  initial begin
    logic                   m;
    logic [COORD_BITS-1:0]  px, py;
    logic [RADIUS_BITS-1:0] rad;
    logic [WIDTH_BITS-1:0]  w;
    logic [HEIGHT_BITS-1:0] ht;
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.mode   <= MODE_CIRCLE;
    in_chan.pos_x  <= '0;
    in_chan.pos_y  <= '0;
    in_chan.radius <= '0;
    in_chan.width  <= '0;
    in_chan.height <= '0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // circles: zero radius with and without pixels, extremes, small ones
    send_shape(MODE_CIRCLE, 0, 0, 0, 0, 0);
    send_shape(MODE_CIRCLE, 1, 0, 0, 1023, 127);
    send_shape(MODE_CIRCLE, 2047, 2047, 31, 0, 0);
    send_shape(MODE_CIRCLE, -2048, -2048, 31, 1023, 64);
    send_shape(MODE_CIRCLE, 5, -3, 1, 0, 0);
    send_shape(MODE_CIRCLE, -1, 1, 16, 0, 0);
    send_shape(MODE_CIRCLE, 0, -1, 2, 0, 0);
    // rectangles: zero height, zero width, one pixel, full size, saturated height
    send_shape(MODE_RECT, 7, 9, 31, 10, 0);
    send_shape(MODE_RECT, -5, 2, 0, 0, 3);
    send_shape(MODE_RECT, 0, 1, 0, 1, 1);
    send_shape(MODE_RECT, 2047, 2047, 0, 1023, 64);
    send_shape(MODE_RECT, -2048, -2048, 31, 1023, 64);
    send_shape(MODE_RECT, -1, -1, 0, 3, 64);
    send_shape(MODE_RECT, 100, -100, 0, 5, 127);
    send_shape(MODE_RECT, 3, 4, 0, 2, 65);
    send_shape(MODE_RECT, 3, 4, 0, 2, 2);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < 100) || (i >= 130 && i < RANDOM_ITEMS - 40);
      if (i == 60)
        hold_req = 1'b1;
      if (i == 140) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      m   = 1'($urandom_range(0, 1));
      px  = COORD_BITS'($urandom);
      py  = COORD_BITS'($urandom);
      w   = WIDTH_BITS'($urandom);
      rad = RADIUS_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, 6));
      case ($urandom_range(0, 9))
        0:       ht = '0;
        1:       ht = HEIGHT_BITS'($urandom_range(65, 127));
        2:       ht = HEIGHT_BITS'($urandom_range(9, 64));
        default: ht = HEIGHT_BITS'($urandom_range(1, 6));
      endcase
      send_shape(m, px, py, rad, w, ht);
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
